@@ hw/rtl/vra_pkg.sv @@
// Package with shared widths, types and the arctangent table of the rotator.
`default_nettype none
package vra_pkg;

  localparam int COORD_BITS = 32;
  localparam int ANGLE_BITS = 16;
  localparam int TRIG_STEPS = 16;

  localparam int TAB_LEN = 30;
  localparam int CELLS   = (TRIG_STEPS < TAB_LEN) ? TRIG_STEPS : TAB_LEN;
  localparam int STEP_W  = 5;
  localparam int TURN_W  = 32;
  localparam int TW      = 32;
  localparam int ZW      = 34;
  localparam int CW      = COORD_BITS;
  localparam int FRAC    = 30;

  localparam logic signed [TW-1:0] GAIN_Q30 = TW'(652032874);

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [TW-1:0] trig_t;
  typedef logic signed [ZW-1:0] resid_t;

  typedef struct packed {
    trig_t  x;
    trig_t  y;
    resid_t z;
    logic   flip;
  } rot_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    rot_t   a;
    rot_t   b;
  } cell_t;

  function automatic logic [TURN_W-1:0] atan_turn(input logic [STEP_W-1:0] idx);
    logic [TURN_W-1:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Folds the angle into the right half plane and sets up the CORDIC start.
  function automatic rot_t rot_init(input logic [ANGLE_BITS-1:0] ang);
    logic [TURN_W-1:0] turn;
    rot_t r;
    turn   = {ang, {(TURN_W-ANGLE_BITS){1'b0}}};
    r.flip = turn[TURN_W-2] ^ turn[TURN_W-1];
    if (r.flip) begin
      turn[TURN_W-1] = ~turn[TURN_W-1];
    end
    r.x = GAIN_Q30;
    r.y = '0;
    r.z = {{(ZW-TURN_W){turn[TURN_W-1]}}, turn};
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/vra_in_if.sv @@
// Input channel interface: one point and two angles per beat.
`default_nettype none
interface vra_in_if import vra_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [CW-1:0]  coord_x;
  logic signed [CW-1:0]  coord_y;
  logic signed [CW-1:0]  coord_z;
  logic [ANGLE_BITS-1:0] angle_alpha;
  logic [ANGLE_BITS-1:0] angle_beta;

  modport source(output valid, coord_x, coord_y, coord_z, angle_alpha, angle_beta,
                 input ready);
  modport sink(input valid, coord_x, coord_y, coord_z, angle_alpha, angle_beta,
               output ready);
endinterface
`default_nettype wire

@@ hw/rtl/vra_out_if.sv @@
// Output channel interface: one rotated point per beat.
`default_nettype none
interface vra_out_if import vra_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] rot_x;
  logic signed [CW-1:0] rot_y;
  logic signed [CW-1:0] rot_z;
  logic                 saturated;

  modport source(output valid, rot_x, rot_y, rot_z, saturated, input ready);
  modport sink(input valid, rot_x, rot_y, rot_z, saturated, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/vra_cordic_cell.sv @@
// One CORDIC iteration for both angles, with the point carried alongside.
`default_nettype none
module vra_cordic_cell import vra_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic [STEP_W-1:0] step_i,
  input  wire logic              vld_i,
  input  wire cell_t             cell_i,
  output logic                   vld_o,
  output cell_t                  cell_o
);

  logic  vld_q;
  cell_t cell_q, cell_d;
  resid_t ang;

  function automatic rot_t rot_step(input rot_t r, input logic [STEP_W-1:0] s,
                                    input resid_t a);
    rot_t  o;
    trig_t sx, sy;
    sx = r.x >>> s;
    sy = r.y >>> s;
    o.flip = r.flip;
    if (!r.z[ZW-1]) begin
      o.x = r.x - sy;
      o.y = r.y + sx;
      o.z = r.z - a;
    end else begin
      o.x = r.x + sy;
      o.y = r.y - sx;
      o.z = r.z + a;
    end
    return o;
  endfunction

  always_comb begin
    ang      = {{(ZW-TURN_W){1'b0}}, atan_turn(step_i)};
    cell_d   = cell_i;
    cell_d.a = rot_step(cell_i.a, step_i, ang);
    cell_d.b = rot_step(cell_i.b, step_i, ang);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign vld_o  = vld_q;
  assign cell_o = cell_q;

endmodule
`default_nettype wire

@@ hw/rtl/vra_mix.sv @@
// Coefficient products, point products, rounding, sums and clipping.
`default_nettype none
module vra_mix import vra_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  input  wire logic  vld_i,
  input  wire cell_t cell_i,
  output logic       vld_o,
  output coord_t     rot_x_o,
  output coord_t     rot_y_o,
  output coord_t     rot_z_o,
  output logic       sat_o
);

  localparam int PT_W   = 2 * TW;
  localparam int PC_W   = CW + TW;
  localparam int TERM_W = PC_W - FRAC;
  localparam int SUM_W  = TERM_W + 2;
  localparam logic signed [SUM_W-1:0] MAX_C = SUM_W'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] MIN_C = -MAX_C - SUM_W'(1);

  typedef logic signed [PT_W-1:0]   pt_t;
  typedef logic signed [PC_W-1:0]   pc_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  logic [5:0] vld_q;

  // Stage A: signed sines and cosines after the half-turn fold.
  trig_t  ca_q, sa_q, cb_q, sb_q;
  coord_t xa_q, ya_q, za_q;
  // Stage B: products of two trig values.
  pt_t    p_cacb_q, p_sacb_q, p_casb_q, p_sasb_q;
  trig_t  cab_q, sab_q, cbb_q, sbb_q;
  coord_t xb_q, yb_q, zb_q;
  // Stage C: coefficients, with the trig products rounded.
  trig_t  k_q [8];
  coord_t xc_q, yc_q, zc_q;
  // Stage D and E: point products and rounded terms.
  pc_t    m_q [8];
  term_t  t_q [8];
  // Stage F: clipped result.
  coord_t rx_q, ry_q, rz_q;
  logic   sat_q;

  function automatic trig_t round_pt(input pt_t p);
    pt_t r;
    r = (p + (PT_W'(1) <<< (FRAC - 1))) >>> FRAC;
    return r[TW-1:0];
  endfunction

  function automatic term_t round_pc(input pc_t p);
    pc_t r;
    r = (p + (PC_W'(1) <<< (FRAC - 1))) >>> FRAC;
    return r[TERM_W-1:0];
  endfunction

  function automatic sum_t ext(input term_t t);
    return SUM_W'(t);
  endfunction

  sum_t sx, sy, sz, cx, cy, cz;
  logic ox, oy, oz;

  always_comb begin
    sx = ext(t_q[0]) - ext(t_q[1]) + ext(t_q[2]);
    sy = ext(t_q[3]) + ext(t_q[4]);
    sz = ext(t_q[5]) - ext(t_q[6]) + ext(t_q[7]);
    ox = (sx > MAX_C) || (sx < MIN_C);
    oy = (sy > MAX_C) || (sy < MIN_C);
    oz = (sz > MAX_C) || (sz < MIN_C);
    cx = (sx > MAX_C) ? MAX_C : ((sx < MIN_C) ? MIN_C : sx);
    cy = (sy > MAX_C) ? MAX_C : ((sy < MIN_C) ? MIN_C : sy);
    cz = (sz > MAX_C) ? MAX_C : ((sz < MIN_C) ? MIN_C : sz);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ca_q <= cell_i.a.flip ? -cell_i.a.x : cell_i.a.x;
      sa_q <= cell_i.a.flip ? -cell_i.a.y : cell_i.a.y;
      cb_q <= cell_i.b.flip ? -cell_i.b.x : cell_i.b.x;
      sb_q <= cell_i.b.flip ? -cell_i.b.y : cell_i.b.y;
      xa_q <= cell_i.x;
      ya_q <= cell_i.y;
      za_q <= cell_i.z;

      p_cacb_q <= PT_W'(ca_q) * PT_W'(cb_q);
      p_sacb_q <= PT_W'(sa_q) * PT_W'(cb_q);
      p_casb_q <= PT_W'(ca_q) * PT_W'(sb_q);
      p_sasb_q <= PT_W'(sa_q) * PT_W'(sb_q);
      cab_q <= ca_q;
      sab_q <= sa_q;
      cbb_q <= cb_q;
      sbb_q <= sb_q;
      xb_q  <= xa_q;
      yb_q  <= ya_q;
      zb_q  <= za_q;

      k_q[0] <= round_pt(p_cacb_q);
      k_q[1] <= round_pt(p_sacb_q);
      k_q[2] <= sbb_q;
      k_q[3] <= sab_q;
      k_q[4] <= cab_q;
      k_q[5] <= round_pt(p_sasb_q);
      k_q[6] <= round_pt(p_casb_q);
      k_q[7] <= cbb_q;
      xc_q <= xb_q;
      yc_q <= yb_q;
      zc_q <= zb_q;

      m_q[0] <= PC_W'(xc_q) * PC_W'(k_q[0]);
      m_q[1] <= PC_W'(yc_q) * PC_W'(k_q[1]);
      m_q[2] <= PC_W'(zc_q) * PC_W'(k_q[2]);
      m_q[3] <= PC_W'(xc_q) * PC_W'(k_q[3]);
      m_q[4] <= PC_W'(yc_q) * PC_W'(k_q[4]);
      m_q[5] <= PC_W'(yc_q) * PC_W'(k_q[5]);
      m_q[6] <= PC_W'(xc_q) * PC_W'(k_q[6]);
      m_q[7] <= PC_W'(zc_q) * PC_W'(k_q[7]);

      for (int i = 0; i < 8; i++) begin
        t_q[i] <= round_pc(m_q[i]);
      end

      rx_q  <= cx[CW-1:0];
      ry_q  <= cy[CW-1:0];
      rz_q  <= cz[CW-1:0];
      sat_q <= ox | oy | oz;
    end
  end

  assign vld_o   = vld_q[5];
  assign rot_x_o = rx_q;
  assign rot_y_o = ry_q;
  assign rot_z_o = rz_q;
  assign sat_o   = sat_q;

endmodule
`default_nettype wire

@@ hw/rtl/vector_rotate_two_angles.sv @@
// Top level of the two-angle point rotator: set-up stage, CORDIC cell row, mixing pipeline.
`default_nettype none
// The block rotates a Q16.16 point by two angles, each given as a fraction of a full turn,
// and returns one saturated Q16.16 point per input beat, with a flag that is set when any
// coordinate had to be clipped. It keeps no state between points. A new point is taken in
// every clock cycle unless a finished result is stalled on the output. Each point passes
// through one set-up stage, one cell per CORDIC step, and six stages of multiplication,
// rounding, summing and clipping. The whole pipeline advances together and holds while a
// finished result waits on the output, so input ready follows output ready whenever the
// output register is full.
module vector_rotate_two_angles import vra_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  vra_in_if.sink    in_i,
  vra_out_if.source out_o
);

  logic  en;
  logic  vld_q;
  cell_t pre_q;

  cell_t chain [CELLS+1];
  logic  chain_vld [CELLS+1];

  // The pipeline moves whenever the output register is empty or being drained.
  assign en        = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= in_i.valid;
    end
  end

  // Set-up: fold each angle into the right half plane and load the CORDIC start vector.
  always_ff @(posedge clk_i) begin
    if (en) begin
      pre_q.x <= in_i.coord_x;
      pre_q.y <= in_i.coord_y;
      pre_q.z <= in_i.coord_z;
      pre_q.a <= rot_init(in_i.angle_alpha);
      pre_q.b <= rot_init(in_i.angle_beta);
    end
  end

  assign chain[0]     = pre_q;
  assign chain_vld[0] = vld_q;

  // One cell per CORDIC step; each cell turns both angles by one table entry.
  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    vra_cordic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .step_i (STEP_W'(g)),
      .vld_i  (chain_vld[g]),
      .cell_i (chain[g]),
      .vld_o  (chain_vld[g+1]),
      .cell_o (chain[g+1])
    );
  end

  vra_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (chain_vld[CELLS]),
    .cell_i  (chain[CELLS]),
    .vld_o   (out_o.valid),
    .rot_x_o (out_o.rot_x),
    .rot_y_o (out_o.rot_y),
    .rot_z_o (out_o.rot_z),
    .sat_o   (out_o.saturated)
  );

  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  // Back-pressure only ever comes from a waiting result.
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("input stalled with an empty output register");

  // A stalled result stays on the output and the pipeline behind it does not move.
  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(chain_vld[CELLS]))
    else $error("pipeline moved while a result was stalled");

  // A clipped result has at least one coordinate at a range limit.
  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.saturated |->
      (out_o.rot_x == CMAX) || (out_o.rot_x == CMIN) ||
      (out_o.rot_y == CMAX) || (out_o.rot_y == CMIN) ||
      (out_o.rot_z == CMAX) || (out_o.rot_z == CMIN))
    else $error("saturation flagged without a clipped coordinate");

endmodule
`default_nettype wire
